FILE: sv/scbpa_pkg.sv
// package for the size class block pool allocator
// payload structs, status and operation codes, config register map, rounding helpers
// no dependencies
`timescale 1ns / 1ps

package scbpa_pkg;

  localparam int unsigned NUM_CLASSES         = 4;
  localparam int unsigned BLOCKS_PER_CLASS    = 16;
  // both alignments are powers of two, rounding is an add and a mask
  localparam int unsigned REQUEST_ALIGN_BYTES = 8;
  localparam int unsigned CLASS_ALIGN_BYTES   = 8;

  localparam int unsigned CLASS_W      = 2;
  localparam int unsigned SLOT_W       = 4;
  localparam int unsigned CNT_W        = 5;
  localparam int unsigned BYTES_W      = 16;
  localparam int unsigned USED_W       = 24;
  localparam int unsigned TOTAL_W      = 32;
  localparam int unsigned ADDR_W       = CLASS_W + SLOT_W;
  localparam int unsigned NUM_BLOCKS   = NUM_CLASSES * BLOCKS_PER_CLASS;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 16;

  localparam logic [BYTES_W-1:0] CLASS_BYTES_RST [NUM_CLASSES] =
    '{16'd64, 16'd256, 16'd1024, 16'd4096};
  localparam logic [CNT_W-1:0] CLASS_COUNT_RST [NUM_CLASSES] =
    '{5'd16, 5'd8, 5'd4, 5'd2};

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_INIT,
    OP_SHUTDOWN
  } op_e;

  typedef enum logic [2:0] {
    ST_OK,
    ST_ZERO_SIZE,
    ST_NO_BLOCK,
    ST_BAD_FREE,
    ST_INIT_ERR,
    ST_ALREADY_INIT,
    ST_NOT_INIT,
    ST_RSVD
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_C0_BYTES,
    REG_C1_BYTES,
    REG_C2_BYTES,
    REG_C3_BYTES,
    REG_C0_COUNT,
    REG_C1_COUNT,
    REG_C2_COUNT,
    REG_C3_COUNT
  } cfg_reg_e;

  typedef enum logic {
    CS_IDLE,
    CS_RESP
  } ctrl_state_e;

  typedef struct packed {
    op_e                operation;
    logic [BYTES_W-1:0] request_bytes;
    logic [CLASS_W-1:0] handle_class;
    logic [SLOT_W-1:0]  handle_slot;
  } in_item_t;

  typedef struct packed {
    status_e            status;
    logic [CLASS_W-1:0] granted_class;
    logic [SLOT_W-1:0]  granted_slot;
    logic [BYTES_W-1:0] granted_bytes;
    logic [CNT_W-1:0]   class_free_blocks;
    logic [USED_W-1:0]  bytes_in_use;
    logic [USED_W-1:0]  peak_bytes_in_use;
    logic [TOTAL_W-1:0] bytes_allocated_total;
  } out_item_t;

  typedef struct packed {
    logic exec;  // input transfer, run the operation
    logic load;  // move the pending result into the output register
  } ctrl_cmd_t;

  // round up to the class alignment, one extra bit shows overflow
  function automatic logic [BYTES_W:0] round_class(input logic [BYTES_W-1:0] v);
    logic [BYTES_W:0] s;
    s = {1'b0, v} + (BYTES_W+1)'(CLASS_ALIGN_BYTES - 1);
    return s & ~((BYTES_W+1)'(CLASS_ALIGN_BYTES - 1));
  endfunction

  function automatic logic [BYTES_W:0] round_req(input logic [BYTES_W-1:0] v);
    logic [BYTES_W:0] s;
    s = {1'b0, v} + (BYTES_W+1)'(REQUEST_ALIGN_BYTES - 1);
    return s & ~((BYTES_W+1)'(REQUEST_ALIGN_BYTES - 1));
  endfunction

endpackage

FILE: sv/scbpa_ctrl.sv
// controller for the size class block pool allocator
// two state machine that runs the handshakes and drives datapath commands
// depends on scbpa_pkg
`timescale 1ns / 1ps

module scbpa_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output scbpa_pkg::ctrl_cmd_t cmd_o
);
  import scbpa_pkg::*;

  ctrl_state_e state_q, state_d;
  logic        out_valid_q, out_valid_d;
  logic        out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CS_IDLE: begin
        if (in_valid_i) state_d = CS_RESP;
      end
      CS_RESP: begin
        if (out_free) state_d = CS_IDLE;
      end
      default: state_d = CS_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != CS_IDLE);
    cmd_o.exec  = (state_q == CS_IDLE) && in_valid_i;
    cmd_o.load  = (state_q == CS_RESP) && out_free;
    out_valid_d = cmd_o.load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= CS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: sv/scbpa_dp.sv
// datapath for the size class block pool allocator
// config registers, class state, free stack memory, counters and output register
// depends on scbpa_pkg
`timescale 1ns / 1ps

module scbpa_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [scbpa_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [scbpa_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  scbpa_pkg::ctrl_cmd_t                cmd_i,
  input  scbpa_pkg::in_item_t                 in_data_i,
  output scbpa_pkg::out_item_t                out_data_o
);
  import scbpa_pkg::*;

  typedef struct packed {
    status_e            status;
    logic [CLASS_W-1:0] gclass;
    logic [BYTES_W-1:0] gbytes;
    logic [CNT_W-1:0]   cls_free;
    logic               granted;
    logic               from_mem;
    logic [SLOT_W-1:0]  init_slot;
  } pend_t;

  // config registers
  logic [BYTES_W-1:0] cfg_bytes_q [NUM_CLASSES];
  logic [CNT_W-1:0]   cfg_count_q [NUM_CLASSES];

  // class state
  logic [BYTES_W-1:0]      cb_q [NUM_CLASSES];
  logic [BYTES_W-1:0]      cb_d [NUM_CLASSES];
  logic [CNT_W-1:0]        fc_q [NUM_CLASSES];
  logic [CNT_W-1:0]        fc_d [NUM_CLASSES];
  logic [CNT_W-1:0]        lw_q [NUM_CLASSES];
  logic [CNT_W-1:0]        lw_d [NUM_CLASSES];
  logic [NUM_BLOCKS-1:0]   alloc_q, alloc_d;
  logic [USED_W-1:0]       used_q, used_d;
  logic [USED_W-1:0]       peak_q, peak_d;
  logic [TOTAL_W-1:0]      life_q, life_d;
  logic                    ready_q, ready_d;

  // free stack memory
  logic [SLOT_W-1:0] mem [NUM_BLOCKS];
  logic [SLOT_W-1:0] rd_q;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;

  pend_t     pend_q, pend_d;
  out_item_t out_q;

  // init values from config
  logic [BYTES_W:0]        rnd_c   [NUM_CLASSES];
  logic [BYTES_W-1:0]      init_cb [NUM_CLASSES];
  logic [NUM_CLASSES-1:0]  init_ok_c;
  logic                    init_ok;

  // state seen by an item: own state, or fresh init values for a lazy init
  logic [BYTES_W-1:0]      base_cb [NUM_CLASSES];
  logic [CNT_W-1:0]        base_fc [NUM_CLASSES];
  logic [CNT_W-1:0]        base_lw [NUM_CLASSES];
  logic [NUM_BLOCKS-1:0]   base_alloc;
  logic [USED_W-1:0]       base_used, base_peak;
  logic [TOTAL_W-1:0]      base_life;

  // allocate path
  logic [BYTES_W:0]       want;
  logic [NUM_CLASSES-1:0] fit;
  logic [CLASS_W-1:0]     pick;
  logic [CNT_W-1:0]       pop_idx;
  logic                   pop_init;
  logic [BYTES_W-1:0]     grant;
  logic [TOTAL_W:0]       life_sum;
  logic [USED_W:0]        used_sum;
  logic [TOTAL_W-1:0]     life_new;
  logic [USED_W-1:0]      used_new, peak_new;

  // free path
  logic [ADDR_W-1:0]  hidx;
  logic               free_ok;
  logic [USED_W-1:0]  free_sz, used_free;

  logic [SLOT_W-1:0]  slot_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cfg_bytes_q[c] <= CLASS_BYTES_RST[c];
        cfg_count_q[c] <= CLASS_COUNT_RST[c];
      end
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_C0_BYTES: cfg_bytes_q[0] <= cfg_wdata_i[BYTES_W-1:0];
        REG_C1_BYTES: cfg_bytes_q[1] <= cfg_wdata_i[BYTES_W-1:0];
        REG_C2_BYTES: cfg_bytes_q[2] <= cfg_wdata_i[BYTES_W-1:0];
        REG_C3_BYTES: cfg_bytes_q[3] <= cfg_wdata_i[BYTES_W-1:0];
        REG_C0_COUNT: cfg_count_q[0] <= cfg_wdata_i[CNT_W-1:0];
        REG_C1_COUNT: cfg_count_q[1] <= cfg_wdata_i[CNT_W-1:0];
        REG_C2_COUNT: cfg_count_q[2] <= cfg_wdata_i[CNT_W-1:0];
        REG_C3_COUNT: cfg_count_q[3] <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      rnd_c[c]     = round_class(cfg_bytes_q[c]);
      init_cb[c]   = rnd_c[c][BYTES_W-1:0];
      init_ok_c[c] = (cfg_bytes_q[c] != '0) && (cfg_count_q[c] != '0) &&
                     (cfg_count_q[c] <= CNT_W'(BLOCKS_PER_CLASS)) && !rnd_c[c][BYTES_W];
    end
    init_ok = &init_ok_c;
  end

  always_comb begin
    for (int c = 0; c < NUM_CLASSES; c++) begin
      base_cb[c] = ready_q ? cb_q[c] : init_cb[c];
      base_fc[c] = ready_q ? fc_q[c] : cfg_count_q[c];
      base_lw[c] = ready_q ? lw_q[c] : cfg_count_q[c];
    end
    base_alloc = ready_q ? alloc_q : '0;
    base_used  = ready_q ? used_q  : '0;
    base_peak  = ready_q ? peak_q  : '0;
    base_life  = ready_q ? life_q  : '0;
  end

  // first fitting class in index order, then pop its stack top
  always_comb begin
    want = round_req(in_data_i.request_bytes);
    for (int c = 0; c < NUM_CLASSES; c++) begin
      fit[c] = ({1'b0, base_cb[c]} >= want) && (base_fc[c] != '0);
    end
    pick = '0;
    for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
      if (fit[c]) pick = CLASS_W'(c);
    end
    pop_idx  = base_fc[pick] - CNT_W'(1);
    // entries below the low-water mark still hold their init value
    pop_init = (pop_idx < base_lw[pick]);
    grant    = base_cb[pick];
    life_sum = {1'b0, base_life} + (TOTAL_W+1)'(grant);
    used_sum = {1'b0, base_used} + (USED_W+1)'(grant);
    life_new = life_sum[TOTAL_W] ? '1 : life_sum[TOTAL_W-1:0];
    used_new = used_sum[USED_W] ? '1 : used_sum[USED_W-1:0];
    peak_new = (used_new > base_peak) ? used_new : base_peak;
  end

  always_comb begin
    hidx      = {in_data_i.handle_class, in_data_i.handle_slot};
    free_ok   = (32'(in_data_i.handle_class) < NUM_CLASSES) &&
                (32'(in_data_i.handle_slot) < BLOCKS_PER_CLASS) &&
                alloc_q[hidx] &&
                (fc_q[in_data_i.handle_class] < CNT_W'(BLOCKS_PER_CLASS));
    free_sz   = USED_W'(cb_q[in_data_i.handle_class]);
    used_free = (used_q >= free_sz) ? (used_q - free_sz) : '0;
  end

  assign slot_sel = pend_q.from_mem ? rd_q : pend_q.init_slot;

  always_comb begin
    cb_d      = cb_q;
    fc_d      = fc_q;
    lw_d      = lw_q;
    alloc_d   = alloc_q;
    used_d    = used_q;
    peak_d    = peak_q;
    life_d    = life_q;
    ready_d   = ready_q;
    pend_d    = pend_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = {in_data_i.handle_class, fc_q[in_data_i.handle_class][SLOT_W-1:0]};
    mem_raddr = {pick, pop_idx[SLOT_W-1:0]};

    if (cmd_i.exec) begin
      pend_d = '0;
      pend_d.status = ST_OK;
      unique case (in_data_i.operation)
        OP_ALLOC: begin
          if (!ready_q && !init_ok) begin
            pend_d.status = ST_INIT_ERR;
          end else begin
            // a lazy init commits even when the allocate then fails
            cb_d    = base_cb;
            fc_d    = base_fc;
            lw_d    = base_lw;
            alloc_d = base_alloc;
            used_d  = base_used;
            peak_d  = base_peak;
            life_d  = base_life;
            ready_d = 1'b1;
            if (in_data_i.request_bytes == '0) begin
              pend_d.status = ST_ZERO_SIZE;
            end else if (!(|fit)) begin
              pend_d.status = ST_NO_BLOCK;
            end else begin
              fc_d[pick]       = pop_idx;
              used_d           = used_new;
              peak_d           = peak_new;
              life_d           = life_new;
              pend_d.gclass    = pick;
              pend_d.gbytes    = grant;
              pend_d.cls_free  = pop_idx;
              pend_d.granted   = 1'b1;
              pend_d.from_mem  = !pop_init;
              pend_d.init_slot = pop_idx[SLOT_W-1:0];
              mem_re           = !pop_init;
              if (pop_init) lw_d[pick] = pop_idx;
            end
          end
        end
        OP_FREE: begin
          if (!ready_q) begin
            pend_d.status = ST_NOT_INIT;
          end else if (!free_ok) begin
            pend_d.status = ST_BAD_FREE;
          end else begin
            alloc_d[hidx]                   = 1'b0;
            mem_we                          = 1'b1;
            fc_d[in_data_i.handle_class]    = fc_q[in_data_i.handle_class] + CNT_W'(1);
            used_d                          = used_free;
            pend_d.cls_free                 = fc_q[in_data_i.handle_class] + CNT_W'(1);
          end
        end
        OP_INIT: begin
          if (ready_q) begin
            pend_d.status = ST_ALREADY_INIT;
          end else if (!init_ok) begin
            pend_d.status = ST_INIT_ERR;
          end else begin
            cb_d    = base_cb;
            fc_d    = base_fc;
            lw_d    = base_lw;
            alloc_d = '0;
            used_d  = '0;
            peak_d  = '0;
            life_d  = '0;
            ready_d = 1'b1;
          end
        end
        OP_SHUTDOWN: begin
          if (!ready_q) begin
            pend_d.status = ST_NOT_INIT;
          end else begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
              cb_d[c] = '0;
              fc_d[c] = '0;
              lw_d[c] = '0;
            end
            alloc_d = '0;
            used_d  = '0;
            peak_d  = '0;
            life_d  = '0;
            ready_d = 1'b0;
          end
        end
        default: ;
      endcase
    end else if (cmd_i.load && pend_q.granted) begin
      // the popped slot is known only once the stack read returns
      alloc_d[{pend_q.gclass, slot_sel}] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        cb_q[c] <= '0;
        fc_q[c] <= '0;
        lw_q[c] <= '0;
      end
      alloc_q <= '0;
      used_q  <= '0;
      peak_q  <= '0;
      life_q  <= '0;
      ready_q <= 1'b0;
    end else begin
      cb_q    <= cb_d;
      fc_q    <= fc_d;
      lw_q    <= lw_d;
      alloc_q <= alloc_d;
      used_q  <= used_d;
      peak_q  <= peak_d;
      life_q  <= life_d;
      ready_q <= ready_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= in_data_i.handle_slot;
    if (mem_re) rd_q <= mem[mem_raddr];
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (cmd_i.load) begin
      out_q.status                <= pend_q.status;
      out_q.granted_class         <= pend_q.gclass;
      out_q.granted_slot          <= pend_q.granted ? slot_sel : '0;
      out_q.granted_bytes         <= pend_q.gbytes;
      out_q.class_free_blocks     <= pend_q.cls_free;
      out_q.bytes_in_use          <= used_q;
      out_q.peak_bytes_in_use     <= peak_q;
      out_q.bytes_allocated_total <= life_q;
    end
  end

  assign out_data_o = out_q;

endmodule

FILE: sv/size_class_block_pool_allocator.sv
// Size class block pool allocator: four classes of fixed-size blocks, each a LIFO free stack
// whose first pop after init yields the highest slot. Operations are allocate, free, init
// and shut down; each input transfer produces exactly one result transfer. In the idle
// state the accept cycle runs the operation and issues the free stack read; the response
// state then loads the output register once it is empty or being taken. The load waits
// for the response state because the stack read for a pop is registered. A new
// item is accepted while a result still waits in the output register. There is no clearing
// pass after reset: a per-class low-water mark tells which stack entries still hold their
// init value, so init and shut down take effect at once. Config registers 0..3 hold the
// block bytes of classes 0..3, registers 4..7 their block counts; write them only while idle.
// depends on scbpa_pkg, scbpa_ctrl, scbpa_dp
`timescale 1ns / 1ps

module size_class_block_pool_allocator (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  scbpa_pkg::in_item_t              in_data_i,
  // result channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output scbpa_pkg::out_item_t             out_data_o,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [scbpa_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [scbpa_pkg::CFG_DATA_W-1:0] cfg_wdata_i
);
  import scbpa_pkg::*;

  // commands from the controller: exec on an input transfer, load into the output register
  ctrl_cmd_t cmd;

  // handshake control and sequencing
  scbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // pool state, free stacks, counters and output payload
  scbpa_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: sv/scbpa_checker.sv
// port level checks for the size class block pool allocator
// bound to the top level; depends on scbpa_pkg
`timescale 1ns / 1ps

module scbpa_checker (
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_stall_o,
  input logic                  out_valid_o,
  input logic                  out_stall_i,
  input scbpa_pkg::out_item_t  out_data_o
);
  import scbpa_pkg::*;

  // one item at a time: an input transfer closes the input side for the next cycle
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on consecutive cycles");

  // with an empty output register the result follows an input transfer without waiting on the output stall
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |-> ##2 out_valid_o)
    else $error("result missing two cycles after input transfer");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // only a successful operation reports a grant or a free count
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_data_o.status != ST_OK) |->
      (out_data_o.granted_bytes == '0) && (out_data_o.granted_class == '0) &&
      (out_data_o.granted_slot == '0) && (out_data_o.class_free_blocks == '0))
    else $error("failed operation reports a grant");

  // the high-water mark never trails bytes in use
  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.peak_bytes_in_use >= out_data_o.bytes_in_use)
    else $error("peak below bytes in use");

endmodule

bind size_class_block_pool_allocator scbpa_checker u_scbpa_checker (.*);

FILE: bench/pool_alloc_checker.sv
// checker for the size class block pool allocator: mirrors config writes, predicts one
// reply per input transfer and compares every result transfer against the oldest reply due
// depends on scbpa_pkg
`timescale 1ns / 1ps

module pool_alloc_checker
  import scbpa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  in_item_t              in_data_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  out_item_t             out_data_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i,
  output int                    mismatches_o,
  output int                    replies_owed_o
);

  localparam int unsigned        MAX_PRINTS = 100;
  localparam int unsigned        BYTES_MAX  = (1 << BYTES_W) - 1;
  localparam logic [USED_W-1:0]  USED_MAX   = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

  // register mirror
  logic [BYTES_W-1:0] reg_bytes [NUM_CLASSES];
  logic [CNT_W-1:0]   reg_count [NUM_CLASSES];

  // pool state
  logic [SLOT_W-1:0]  stack_slot [NUM_BLOCKS];
  logic [CNT_W-1:0]   free_left  [NUM_CLASSES];
  logic               taken      [NUM_BLOCKS];
  logic [BYTES_W-1:0] blk_bytes  [NUM_CLASSES];
  logic [USED_W-1:0]  used_now;
  logic [USED_W-1:0]  used_peak;
  logic [TOTAL_W-1:0] granted_sum;
  logic               pools_up;

  out_item_t replies_due [$];
  out_item_t due;
  int        mismatch_cnt = 0;
  int        owed_cnt     = 0;

  assign mismatches_o   = mismatch_cnt;
  assign replies_owed_o = owed_cnt;

  function automatic void clear_pools();
    for (int i = 0; i < NUM_BLOCKS; i++) begin
      stack_slot[i] = '0;
      taken[i]      = 1'b0;
    end
    for (int c = 0; c < NUM_CLASSES; c++) begin
      free_left[c] = '0;
      blk_bytes[c] = '0;
    end
    used_now    = '0;
    used_peak   = '0;
    granted_sum = '0;
    pools_up    = 1'b0;
  endfunction

  function automatic status_e build_pools();
    int unsigned rounded;
    clear_pools();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      rounded = (int'(reg_bytes[c]) + CLASS_ALIGN_BYTES - 1) / CLASS_ALIGN_BYTES
                * CLASS_ALIGN_BYTES;
      if (reg_bytes[c] == 0 || reg_count[c] == 0 || reg_count[c] > BLOCKS_PER_CLASS ||
          rounded > BYTES_MAX) begin
        clear_pools();
        return ST_INIT_ERR;
      end
      blk_bytes[c] = BYTES_W'(rounded);
      // stack filled bottom up so the first pop gives the highest slot
      for (int j = 0; j < int'(reg_count[c]); j++)
        stack_slot[c * BLOCKS_PER_CLASS + j] = SLOT_W'(j);
      free_left[c] = reg_count[c];
    end
    pools_up = 1'b1;
    return ST_OK;
  endfunction

  function automatic out_item_t compute_pool_reply(in_item_t item);
    out_item_t       r;
    int unsigned     want;
    int unsigned     pos;
    int unsigned     hc;
    longint unsigned sum;
    logic            placed;
    r        = '0;
    r.status = ST_OK;
    placed   = 1'b0;
    hc       = item.handle_class;
    case (item.operation)
      OP_ALLOC: begin
        // lazy init, also in front of a zero size
        if (!pools_up) r.status = build_pools();
        if (r.status == ST_OK) begin
          want = (int'(item.request_bytes) + REQUEST_ALIGN_BYTES - 1) / REQUEST_ALIGN_BYTES
                 * REQUEST_ALIGN_BYTES;
          if (item.request_bytes == 0) begin
            r.status = ST_ZERO_SIZE;
          end else begin
            for (int c = 0; c < NUM_CLASSES; c++) begin
              if (!placed && blk_bytes[c] >= want && free_left[c] != 0) begin
                placed       = 1'b1;
                free_left[c] = free_left[c] - 1'b1;
                pos          = c * BLOCKS_PER_CLASS + free_left[c];
                taken[c * BLOCKS_PER_CLASS + stack_slot[pos]] = 1'b1;
                r.granted_class     = CLASS_W'(c);
                r.granted_slot      = stack_slot[pos];
                r.granted_bytes     = blk_bytes[c];
                r.class_free_blocks = free_left[c];
                sum         = longint'(granted_sum) + blk_bytes[c];
                granted_sum = (sum > TOTAL_MAX) ? TOTAL_MAX : TOTAL_W'(sum);
                sum         = longint'(used_now) + blk_bytes[c];
                used_now    = (sum > USED_MAX) ? USED_MAX : USED_W'(sum);
                if (used_now > used_peak) used_peak = used_now;
              end
            end
            if (!placed) r.status = ST_NO_BLOCK;
          end
        end
      end
      OP_FREE: begin
        pos = hc * BLOCKS_PER_CLASS + item.handle_slot;
        if (!pools_up) begin
          r.status = ST_NOT_INIT;
        end else if (hc >= NUM_CLASSES || item.handle_slot >= BLOCKS_PER_CLASS ||
                     !taken[pos] || free_left[hc] >= BLOCKS_PER_CLASS) begin
          r.status = ST_BAD_FREE;
        end else begin
          taken[pos] = 1'b0;
          stack_slot[hc * BLOCKS_PER_CLASS + free_left[hc]] = item.handle_slot;
          free_left[hc]       = free_left[hc] + 1'b1;
          used_now            = (used_now >= blk_bytes[hc]) ? used_now - blk_bytes[hc] : '0;
          r.class_free_blocks = free_left[hc];
        end
      end
      OP_INIT: begin
        if (pools_up) r.status = ST_ALREADY_INIT;
        else r.status = build_pools();
      end
      default: begin
        if (!pools_up) r.status = ST_NOT_INIT;
        else clear_pools();
      end
    endcase
    r.bytes_in_use          = used_now;
    r.peak_bytes_in_use     = used_peak;
    r.bytes_allocated_total = granted_sum;
    return r;
  endfunction

  task automatic report_mismatch(string msg);
    mismatch_cnt++;
    if (mismatch_cnt <= MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CLASSES; c++) begin
        reg_bytes[c] = CLASS_BYTES_RST[c];
        reg_count[c] = CLASS_COUNT_RST[c];
      end
      clear_pools();
      replies_due.delete();
    end else begin
      // a result never belongs to the item accepted at the same edge
      if (out_valid_i && !out_stall_i) begin
        if (replies_due.size() == 0) begin
          report_mismatch("result transfer with no reply pending");
        end else begin
          due = replies_due.pop_front();
          check_field("status", out_data_i.status, due.status);
          check_field("granted_class", out_data_i.granted_class, due.granted_class);
          check_field("granted_slot", out_data_i.granted_slot, due.granted_slot);
          check_field("granted_bytes", out_data_i.granted_bytes, due.granted_bytes);
          check_field("class_free_blocks", out_data_i.class_free_blocks,
                      due.class_free_blocks);
          check_field("bytes_in_use", out_data_i.bytes_in_use, due.bytes_in_use);
          check_field("peak_bytes_in_use", out_data_i.peak_bytes_in_use,
                      due.peak_bytes_in_use);
          check_field("bytes_allocated_total", out_data_i.bytes_allocated_total,
                      due.bytes_allocated_total);
        end
      end
      if (in_valid_i && !in_stall_i) replies_due.push_back(compute_pool_reply(in_data_i));
      if (cfg_we_i) begin
        if (cfg_idx_i <= REG_C3_BYTES) reg_bytes[cfg_idx_i] = cfg_wdata_i;
        else reg_count[cfg_idx_i - REG_C0_COUNT] = cfg_wdata_i[CNT_W-1:0];
      end
    end
    owed_cnt = replies_due.size();
  end

endmodule

FILE: bench/tb_size_class_block_pool_allocator.sv
// top of the size class block pool allocator bench: clock, reset, stimulus, config phases
// and the verdict; checking lives in pool_alloc_checker
// depends on scbpa_pkg, pool_alloc_checker, size_class_block_pool_allocator
`timescale 1ns / 1ps

module tb_size_class_block_pool_allocator;
  import scbpa_pkg::*;

  localparam int unsigned NUM_PHASES      = 8;
  localparam int unsigned PHASE_ITEMS     = 230;
  localparam int unsigned BAD_PHASE       = 4;
  localparam int unsigned BAD_PHASE_ITEMS = 40;
  localparam int unsigned TAIL_CYCLES     = 20;
  localparam int unsigned MAX_WAIT        = 13;
  // largest block size that still rounds up inside 16 bits
  localparam int unsigned BYTES_ROUND_MAX = (1 << BYTES_W) - CLASS_ALIGN_BYTES;
  localparam int unsigned BYTES_MAX       = (1 << BYTES_W) - 1;
  localparam int unsigned COUNT_MAX       = (1 << CNT_W) - 1;
  localparam longint      CYCLE_LIMIT     = 300000;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_item_t              in_data;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we;
  cfg_reg_e              cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int     mismatches;
  int     replies_owed;
  longint cycle_cnt = 0;

  // stimulus view of the registers, used to aim request sizes at class boundaries
  logic [BYTES_W-1:0] cur_bytes [NUM_CLASSES];
  logic [CNT_W-1:0]   cur_count [NUM_CLASSES];

  // handles granted so far and not yet returned, {class, slot}
  logic [ADDR_W-1:0] live_blocks [$];

  int   in_quiet  = 0;
  int   out_quiet = 0;
  int   out_hold  = 0;
  logic out_taken = 1'b0;

  size_class_block_pool_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  pool_alloc_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .out_data_i     (out_data),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_wdata_i    (cfg_wdata),
    .mismatches_o   (mismatches),
    .replies_owed_o (replies_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
  end

  // watchdog, a hung handshake or a lost result ends up here
  initial begin
    wait (cycle_cnt >= CYCLE_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  // wait length per transfer: 0..MAX_WAIT, with the odd stretch of back-to-back traffic
  function automatic int draw_wait(inout int quiet_left);
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      quiet_left = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, MAX_WAIT);
  endfunction

  // collect granted handles so frees can mostly return real blocks
  always @(posedge clk) begin
    out_taken <= out_valid && !out_stall;
    if (out_valid && !out_stall && out_data.status == ST_OK && out_data.granted_bytes != 0)
      live_blocks.push_back({out_data.granted_class, out_data.granted_slot});
  end

  // result side: hold each result stalled for a drawn number of cycles
  always @(negedge clk) begin
    if (out_taken) out_hold = draw_wait(out_quiet);
    if (out_valid === 1'b1 && out_hold > 0) begin
      out_stall = 1'b1;
      out_hold--;
    end else if (out_valid === 1'b1) begin
      out_stall = 1'b0;
    end else begin
      // stall while idle is legal and shakes the output register
      out_stall = ($urandom_range(0, 3) == 0);
    end
  end

  // one input transfer; entered and left at a falling edge, valid stays high
  // after acceptance so a zero gap gives back-to-back items
  task automatic send_op(op_e op, logic [BYTES_W-1:0] bytes, logic [CLASS_W-1:0] cls,
                         logic [SLOT_W-1:0] slot);
    int gap;
    gap = draw_wait(in_quiet);
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid                = 1'b1;
    in_data.operation       = op;
    in_data.request_bytes   = bytes;
    in_data.handle_class    = cls;
    in_data.handle_slot     = slot;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // every reply in, then a few cycles so the block is idle for a register write
  task automatic settle();
    in_valid = 1'b0;
    while (replies_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = data;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // all eight registers; count writes carry random upper bits the block must drop
  task automatic load_pool_config();
    settle();
    for (int c = 0; c < NUM_CLASSES; c++) begin
      write_reg(cfg_reg_e'(REG_C0_BYTES + c), cur_bytes[c]);
      write_reg(cfg_reg_e'(REG_C0_COUNT + c),
                {(CFG_DATA_W-CNT_W)'($urandom()), cur_count[c]});
    end
  endtask

  // random traffic: mostly allocs and frees of live handles, with bad frees,
  // double frees, inits and the odd shutdown mixed in
  task automatic send_random(int alloc_pct);
    int                 roll;
    int                 pick;
    int                 near;
    int                 c;
    logic [BYTES_W-1:0] req;
    logic [ADDR_W-1:0]  blk;
    roll = $urandom_range(0, 99);
    if (roll < alloc_pct) begin
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        req = BYTES_W'($urandom_range(0, 16));
      end else if (pick < 50) begin
        // right around a class size, both sides of the rounding step
        c    = $urandom_range(0, NUM_CLASSES - 1);
        near = int'(cur_bytes[c]) + int'($urandom_range(0, 16)) - 8;
        if (near < 0) near = 0;
        if (near > int'(BYTES_MAX)) near = BYTES_MAX;
        req = BYTES_W'(near);
      end else if (pick < 65) begin
        req = BYTES_W'($urandom());
      end else begin
        req = BYTES_W'($urandom_range(1, 512));
      end
      send_op(OP_ALLOC, req, CLASS_W'($urandom()), SLOT_W'($urandom()));
    end else if (roll < 93) begin
      if (live_blocks.size() > 0 && $urandom_range(0, 7) != 0) begin
        pick = $urandom_range(0, live_blocks.size() - 1);
        blk  = live_blocks[pick];
        // now and then keep the handle so a later free returns it twice
        if ($urandom_range(0, 9) != 0) live_blocks.delete(pick);
      end else begin
        blk = ADDR_W'($urandom());
      end
      send_op(OP_FREE, BYTES_W'($urandom()), blk[ADDR_W-1:SLOT_W], blk[SLOT_W-1:0]);
    end else if (roll < 97) begin
      send_op(OP_INIT, BYTES_W'($urandom()), CLASS_W'($urandom()), SLOT_W'($urandom()));
    end else begin
      live_blocks.delete();
      send_op(OP_SHUTDOWN, BYTES_W'($urandom()), CLASS_W'($urandom()),
              SLOT_W'($urandom()));
    end
  endtask

  initial begin
    int n_items;
    int alloc_pct;
    int c;
    int b;

    // every input known from time zero
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = REG_C0_BYTES;
    cfg_wdata = '0;
    for (int i = 0; i < NUM_CLASSES; i++) begin
      cur_bytes[i] = CLASS_BYTES_RST[i];
      cur_count[i] = CLASS_COUNT_RST[i];
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed part on the reset config (64/256/1024/4096 bytes, 16/8/4/2 blocks)
    send_op(OP_FREE, '0, '0, '0);              // not initialized
    send_op(OP_SHUTDOWN, '0, '0, '0);          // not initialized
    send_op(OP_ALLOC, '0, '0, '0);             // lazy init, then zero size
    send_op(OP_INIT, '0, '0, '0);              // already initialized
    send_op(OP_ALLOC, 16'd1, '0, '0);          // class 0, highest slot first
    send_op(OP_ALLOC, 16'd64, '0, '0);         // exact fit in class 0
    send_op(OP_ALLOC, 16'd65, '0, '0);         // spills to class 1
    send_op(OP_ALLOC, 16'd4096, '0, '0);       // largest class
    send_op(OP_ALLOC, 16'd4097, '0, '0);       // fits nowhere
    send_op(OP_ALLOC, BYTES_W'(BYTES_MAX), '0, '0);  // rounds past 16 bits
    send_op(OP_ALLOC, 16'd4089, '0, '0);       // rounds to 4096, last class 3 block
    send_op(OP_ALLOC, 16'd4000, '0, '0);       // class 3 now empty
    send_op(OP_FREE, '0, 2'd0, 4'd15);         // valid return
    send_op(OP_FREE, '0, 2'd0, 4'd15);         // double free
    send_op(OP_FREE, '0, 2'd3, 4'd5);          // never allocated
    send_op(OP_FREE, '0, 2'd3, 4'd1);          // valid return
    send_op(OP_ALLOC, 16'd8, '0, '0);          // lifo: slot 15 comes back
    send_op(OP_FREE, '1, '1, '1);              // all-ones handle, not allocated
    send_op(OP_SHUTDOWN, '0, '0, '0);          // clears everything
    send_op(OP_SHUTDOWN, '0, '0, '0);          // not initialized again
    send_op(OP_FREE, '0, 2'd1, 4'd7);          // free after shutdown

    // init config errors: zero count, count above the class size, size that
    // rounds past 16 bits, zero size
    settle();
    write_reg(REG_C0_COUNT, '0);
    send_op(OP_INIT, '0, '0, '0);
    send_op(OP_ALLOC, 16'd10, '0, '0);         // lazy init fails the same way
    settle();
    write_reg(REG_C0_COUNT, CFG_DATA_W'(BLOCKS_PER_CLASS + 1));
    send_op(OP_INIT, '0, '0, '0);
    settle();
    write_reg(REG_C0_COUNT, CFG_DATA_W'(BLOCKS_PER_CLASS));
    write_reg(REG_C3_BYTES, CFG_DATA_W'(BYTES_ROUND_MAX + 1));
    send_op(OP_INIT, '0, '0, '0);
    settle();
    write_reg(REG_C3_BYTES, '0);
    send_op(OP_ALLOC, 16'd10, '0, '0);

    // random phases, each on its own register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      for (int i = 0; i < NUM_CLASSES; i++) begin
        cur_bytes[i] = BYTES_W'($urandom_range(1, 8192));
        cur_count[i] = CNT_W'($urandom_range(1, BLOCKS_PER_CLASS));
      end
      case (p)
        0: begin
          // largest legal sizes, full classes
          for (int i = 0; i < NUM_CLASSES; i++) begin
            cur_bytes[i] = BYTES_W'(BYTES_ROUND_MAX);
            cur_count[i] = CNT_W'(BLOCKS_PER_CLASS);
          end
        end
        1: begin
          // one byte rounds to one alignment unit, one block per class
          for (int i = 0; i < NUM_CLASSES; i++) begin
            cur_bytes[i] = BYTES_W'(1);
            cur_count[i] = CNT_W'(1);
          end
        end
        2: begin
          // descending sizes, class 0 takes everything it can
          b = $urandom_range(30000, 60000);
          for (int i = 0; i < NUM_CLASSES; i++) begin
            cur_bytes[i] = BYTES_W'(b);
            b = b / $urandom_range(2, 5);
          end
        end
        BAD_PHASE: begin
          // one class broken, init and lazy init keep failing
          c = $urandom_range(0, NUM_CLASSES - 1);
          case ($urandom_range(0, 3))
            0:       cur_count[c] = '0;
            1:       cur_count[c] = CNT_W'($urandom_range(BLOCKS_PER_CLASS + 1, COUNT_MAX));
            2:       cur_bytes[c] = '0;
            default: cur_bytes[c] = BYTES_W'($urandom_range(BYTES_ROUND_MAX + 1, BYTES_MAX));
          endcase
        end
        5: begin
          // small pools run dry quickly
          for (int i = 0; i < NUM_CLASSES; i++) begin
            cur_bytes[i] = BYTES_W'(i * 512 + $urandom_range(1, 512));
            cur_count[i] = CNT_W'($urandom_range(1, 3));
          end
        end
        6: begin
          for (int i = 0; i < NUM_CLASSES; i++) cur_bytes[i] = BYTES_W'($urandom());
        end
        7: begin
          for (int i = 0; i < NUM_CLASSES; i++) begin
            cur_bytes[i] = CLASS_BYTES_RST[i];
            cur_count[i] = CLASS_COUNT_RST[i];
          end
        end
        default: ;
      endcase
      load_pool_config();
      live_blocks.delete();
      alloc_pct = $urandom_range(40, 70);
      n_items   = (p == BAD_PHASE) ? BAD_PHASE_ITEMS : PHASE_ITEMS;
      // explicit init half the time, otherwise the first alloc brings the pools up
      if ($urandom_range(0, 1) == 1) send_op(OP_INIT, '0, '0, '0);
      repeat (n_items) send_random(alloc_pct);
    end

    // drain, then let the pipe run empty before the verdict
    in_valid = 1'b0;
    while (replies_owed != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
